// ===== sv/lcs_pkg.sv =====
// lcs_pkg: shared constants and types for the lru content store
// used by lcs_ctrl, lcs_dp and lru_content_store; depends on nothing
package lcs_pkg;

  localparam int DEPTH_DEF       = 128;
  localparam int KEY_BITS_DEF    = 64;
  localparam int HANDLE_BITS_DEF = 32;
  localparam int LIMIT_BITS      = 8;
  localparam logic [LIMIT_BITS-1:0] MAX_ENTRIES_RESET = 8'd100;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_SCAN  = 2'd2;
  localparam logic [1:0] MODE_UPD   = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic       start_pass;
    logic       load_req;
    logic       decide;
  } cmd_t;

  typedef struct packed {
    logic addr_last;
    logic rd_last;
    logic need_upd;
  } stat_t;

endpackage

// ===== sv/lcs_ram.sv =====
// lcs_ram: generic single write port, single read port ram with registered read
// no dependencies
module lcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/lcs_ctrl.sv =====
// lcs_ctrl: sequencer for clear, scan, decide and update passes
// depends on lcs_pkg
module lcs_ctrl import lcs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_UPD    = 3'd4;

  logic [2:0] state, state_next;

  always_comb begin
    cmd        = '0;
    cmd.mode   = MODE_IDLE;
    busy       = 1'b1;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.mode = MODE_CLEAR;
        if (stat.addr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load_req   = 1'b1;
          cmd.start_pass = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.mode = MODE_SCAN;
        if (stat.rd_last) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (stat.need_upd) begin
          cmd.start_pass = 1'b1;
          state_next     = S_UPD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_UPD: begin
        cmd.mode = MODE_UPD;
        if (stat.rd_last) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/lcs_dp.sv =====
// lcs_dp: slot memory, sweep counter, scan match logic, recency update, result registers
// depends on lcs_pkg and lcs_ram
module lcs_dp import lcs_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  input  logic                   cfg_wr_en,
  input  logic [LIMIT_BITS-1:0]  cfg_wr_data,
  input  logic                   req_type,
  input  logic [KEY_BITS-1:0]    name_key,
  input  logic [HANDLE_BITS-1:0] content_handle,
  output logic                   done,
  output logic                   hit,
  output logic [HANDLE_BITS-1:0] found_handle,
  output logic                   evicted,
  output logic [KEY_BITS-1:0]    evicted_key
);

  localparam int IW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);
  localparam int LW = (OW > LIMIT_BITS) ? OW : LIMIT_BITS;
  localparam int MW = 1 + IW + KEY_BITS + HANDLE_BITS;
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  logic [LIMIT_BITS-1:0] max_entries;
  logic [OW-1:0]         occ;

  logic          sweep_on, rd_vld;
  logic [IW-1:0] addr, rd_idx;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [MW-1:0] ram_wdata, ram_rdata;

  logic                   req_add;
  logic [KEY_BITS-1:0]    req_key;
  logic [HANDLE_BITS-1:0] req_hnd;

  logic                   found, have_free;
  logic [IW-1:0]          f_idx, f_rec, free_idx, lru_idx;
  logic [HANDLE_BITS-1:0] f_hnd;
  logic [KEY_BITS-1:0]    lru_key;

  logic          upd_hit;
  logic [IW-1:0] sel_idx, hit_rec;

  logic                   rd_v;
  logic [IW-1:0]          rd_rec;
  logic [KEY_BITS-1:0]    rd_key;
  logic [HANDLE_BITS-1:0] rd_hnd;

  logic [LW-1:0] limit;
  logic          full, drop_new;

  lcs_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  assign rd_v   = ram_rdata[MW-1];
  assign rd_rec = ram_rdata[MW-2 -: IW];
  assign rd_key = ram_rdata[KEY_BITS+HANDLE_BITS-1 : HANDLE_BITS];
  assign rd_hnd = ram_rdata[HANDLE_BITS-1:0];

  assign limit    = (LW'(max_entries) >= LW'(DEPTH)) ? LW'(DEPTH) : LW'(max_entries);
  assign full     = LW'(occ) >= limit;
  assign drop_new = full && (occ == '0);

  assign stat.addr_last = sweep_on && (addr == LAST);
  assign stat.rd_last   = rd_vld && (rd_idx == LAST);
  assign stat.need_upd  = found || (req_add && !drop_new);

  // sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_on <= 1'b1;
      addr     <= '0;
      rd_vld   <= 1'b0;
    end else begin
      rd_vld <= sweep_on;
      if (cmd.start_pass) begin
        sweep_on <= 1'b1;
        addr     <= '0;
      end else if (sweep_on) begin
        if (addr == LAST) sweep_on <= 1'b0;
        else addr <= addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= addr;
  end

  // slot rewrite
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_idx;
    ram_wdata = ram_rdata;
    if (cmd.mode == MODE_CLEAR) begin
      ram_we    = sweep_on;
      ram_waddr = addr;
      ram_wdata = '0;
    end else if (cmd.mode == MODE_UPD) begin
      ram_we = rd_vld;
      if (rd_idx == sel_idx) begin
        if (upd_hit) ram_wdata[MW-2 -: IW] = '0;
        else ram_wdata = {1'b1, {IW{1'b0}}, req_key, req_hnd};
      end else if (rd_v && (!upd_hit || rd_rec < hit_rec)) begin
        ram_wdata[MW-2 -: IW] = rd_rec + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_add   <= req_type;
      req_key   <= name_key;
      req_hnd   <= content_handle;
      found     <= 1'b0;
      have_free <= 1'b0;
    end else if (rd_vld && cmd.mode == MODE_SCAN) begin
      if (!found && rd_v && rd_key == req_key) begin
        found <= 1'b1;
        f_idx <= rd_idx;
        f_rec <= rd_rec;
        f_hnd <= rd_hnd;
      end
      if (!have_free && !rd_v) begin
        have_free <= 1'b1;
        free_idx  <= rd_idx;
      end
      if (rd_v && (OW'(rd_rec) + 1'b1 == occ)) begin
        lru_idx <= rd_idx;
        lru_key <= rd_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      hit_rec      <= f_rec;
      upd_hit      <= found;
      hit          <= found;
      found_handle <= found ? f_hnd : '0;
      evicted      <= 1'b0;
      evicted_key  <= '0;
      if (found) begin
        sel_idx <= f_idx;
      end else if (req_add) begin
        if (drop_new) begin
          evicted     <= 1'b1;
          evicted_key <= req_key;
        end else if (full) begin
          evicted     <= 1'b1;
          evicted_key <= lru_key;
          sel_idx     <= lru_idx;
        end else begin
          sel_idx <= free_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      occ         <= '0;
      max_entries <= MAX_ENTRIES_RESET;
    end else begin
      done <= cmd.decide;
      if (cfg_wr_en) max_entries <= cfg_wr_data;
      if (cmd.decide && !found && req_add && !full) occ <= occ + 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_occ_range: assert property (@(posedge clk) disable iff (rst) occ <= OW'(DEPTH))
    else $error("occupancy above depth");
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst) done |-> !(hit && evicted))
    else $error("hit and eviction together");
  a_miss_handle: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> found_handle == '0)
    else $error("handle on a miss");
  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    !$past(cmd.decide) |-> $stable(occ))
    else $error("occupancy changed outside decide");
`endif

endmodule

// ===== sv/lru_content_store.sv =====
// lru_content_store: top level joining the controller and the datapath
// depends on lcs_pkg, lcs_ctrl, lcs_dp
// Each item (lookup or add) is taken when start is high and busy is low and gives exactly one
// result, shown for one cycle with done high; the receiver cannot stall it. One pass over the
// slot memory, one port a cycle, searches for the key; unless nothing changes (lookup miss, or
// add into a store with a limit of zero while empty), a second pass then rewrites the recency
// ranks. After reset a clearing pass over the slot memory runs with busy high; max_entries
// may be written at any idle time.
module lru_content_store import lcs_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [LIMIT_BITS-1:0]  cfg_wr_data,
  input  logic                   start,
  output logic                   busy,
  input  logic                   req_type,
  input  logic [KEY_BITS-1:0]    name_key,
  input  logic [HANDLE_BITS-1:0] content_handle,
  output logic                   done,
  output logic                   hit,
  output logic [HANDLE_BITS-1:0] found_handle,
  output logic                   evicted,
  output logic [KEY_BITS-1:0]    evicted_key
);

  cmd_t  cmd;
  stat_t stat;

  lcs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  lcs_dp #(
    .DEPTH       (DEPTH),
    .KEY_BITS    (KEY_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .req_type       (req_type),
    .name_key       (name_key),
    .content_handle (content_handle),
    .done           (done),
    .hit            (hit),
    .found_handle   (found_handle),
    .evicted        (evicted),
    .evicted_key    (evicted_key)
  );

endmodule

// ===== tb/lru_content_store_test.sv =====
// lru_content_store_test: self-checking testbench for the lru content store
// drives lookup and add items, predicts results with its own lru store model
// depends on lcs_pkg and lru_content_store
`timescale 1ns / 1ps

module lru_content_store_test import lcs_pkg::*; ;

  localparam int DEPTH = DEPTH_DEF;
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_ADD = 1'b1;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    logic        hit;
    logic [31:0] found_handle;
    logic        evicted;
    logic [63:0] evicted_key;
  } lcs_result_t;

  class lru_scoreboard;
    logic        valid_q[DEPTH];
    logic [63:0] key_q[DEPTH];
    logic [31:0] handle_q[DEPTH];
    int          rank_q[DEPTH];
    int          occupancy;
    int          limit_reg;
    lcs_result_t pending[$];
    int          errors;
    int          checked;
    int          hits;
    int          evictions;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        valid_q[i] = 0;
        rank_q[i] = 0;
        key_q[i] = '0;
        handle_q[i] = '0;
      end
      occupancy = 0;
      limit_reg = MAX_ENTRIES_RESET;
      errors = 0;
      checked = 0;
      hits = 0;
      evictions = 0;
    endfunction

    function void note_item(logic rt, logic [63:0] k, logic [31:0] h);
      lcs_result_t r;
      int s;
      int lim;
      int slot;
      int rr;
      r = '{0, 0, 0, 0};
      s = -1;
      lim = (limit_reg < DEPTH) ? limit_reg : DEPTH;
      for (int i = 0; i < DEPTH; i++)
        if (s < 0 && valid_q[i] && key_q[i] == k) s = i;
      if (s >= 0) begin
        r.hit = 1;
        r.found_handle = handle_q[s];
        rr = rank_q[s];
        for (int i = 0; i < DEPTH; i++)
          if (valid_q[i] && rank_q[i] < rr) rank_q[i]++;
        rank_q[s] = 0;
      end else if (rt == REQ_ADD) begin
        if (occupancy + 1 > lim && occupancy == 0) begin
          r.evicted = 1;
          r.evicted_key = k;
        end else begin
          slot = 0;
          if (occupancy + 1 > lim) begin
            for (int i = 0; i < DEPTH; i++)
              if (valid_q[i] && rank_q[i] + 1 == occupancy) slot = i;
            r.evicted = 1;
            r.evicted_key = key_q[slot];
            valid_q[slot] = 0;
            occupancy--;
          end else begin
            for (int i = DEPTH - 1; i >= 0; i--)
              if (!valid_q[i]) slot = i;
          end
          for (int i = 0; i < DEPTH; i++)
            if (valid_q[i]) rank_q[i]++;
          valid_q[slot] = 1;
          key_q[slot] = k;
          handle_q[slot] = h;
          rank_q[slot] = 0;
          occupancy++;
        end
      end
      pending.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    task check_result(lcs_result_t got);
      lcs_result_t e;
      if (pending.size() == 0) begin
        report("unexpected result", 0, 0);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.hit) hits++;
      if (got.evicted) evictions++;
      if (got.hit !== e.hit) report("hit", got.hit, e.hit);
      if (got.found_handle !== e.found_handle)
        report("found_handle", got.found_handle, e.found_handle);
      if (got.evicted !== e.evicted) report("evicted", got.evicted, e.evicted);
      if (got.evicted_key !== e.evicted_key)
        report("evicted_key", got.evicted_key, e.evicted_key);
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_wr_en = 0;
  logic [7:0]  cfg_wr_data = '0;
  logic        start = 0;
  logic        busy;
  logic        req_type = 0;
  logic [63:0] name_key = '0;
  logic [31:0] content_handle = '0;
  logic        done;
  logic        hit;
  logic [31:0] found_handle;
  logic        evicted;
  logic [63:0] evicted_key;

  lru_scoreboard board = new();
  int cycles = 0;
  int idle_pct = 0;
  logic [63:0] key_pool[16];

  always #2 clk = ~clk;

  lru_content_store uut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .start(start), .busy(busy), .req_type(req_type), .name_key(name_key),
    .content_handle(content_handle), .done(done), .hit(hit),
    .found_handle(found_handle), .evicted(evicted), .evicted_key(evicted_key)
  );

  always @(posedge clk) begin
    lcs_result_t r;
    cycles <= cycles + 1;
    if (!rst && done) begin
      r.hit = hit;
      r.found_handle = found_handle;
      r.evicted = evicted;
      r.evicted_key = evicted_key;
      board.check_result(r);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // start stays high between back to back items and is dropped only when idling
  task send_item(logic rt, logic [63:0] k, logic [31:0] h);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start <= 1;
    req_type <= rt;
    name_key <= k;
    content_handle <= h;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_item(rt, k, h);
  endtask

  task drain();
    start <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 10) @(posedge clk);
  endtask

  task set_limit(logic [7:0] v);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    board.limit_reg = v;
  endtask

  task random_items(int n, int pool_span);
    logic [63:0] k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        k = {$urandom, $urandom};
      else
        k = key_pool[$urandom_range(pool_span - 1)] + $urandom_range(3 * pool_span);
      send_item($urandom_range(1), k, $urandom);
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    while (busy) @(posedge clk);

    // directed: extremes, lookups, add hits, limits of 0, 1 and 255
    send_item(REQ_LOOKUP, '0, '0);
    send_item(REQ_ADD, '0, 32'hFFFF_FFFF);
    send_item(REQ_ADD, '1, 32'h0);
    send_item(REQ_LOOKUP, '1, 32'h1234);
    send_item(REQ_ADD, '0, 32'h5555_AAAA);
    send_item(REQ_LOOKUP, 64'hAAAA_5555_AAAA_5555, '1);
    send_item(REQ_ADD, 64'h5555_AAAA_5555_AAAA, 32'hAAAA_5555);
    set_limit(8'd0);
    send_item(REQ_ADD, 64'h1, 32'h1);
    send_item(REQ_ADD, 64'h2, 32'h2);
    send_item(REQ_ADD, 64'h3, 32'h3);
    send_item(REQ_ADD, 64'h4, 32'h4);
    send_item(REQ_LOOKUP, 64'h4, 32'h0);
    set_limit(8'd1);
    send_item(REQ_ADD, 64'h10, 32'h10);
    send_item(REQ_ADD, 64'h11, 32'h11);
    send_item(REQ_LOOKUP, 64'h10, 32'h0);
    set_limit(8'd255);
    for (int i = 0; i < 6; i++) send_item(REQ_ADD, 64'h100 + i, $urandom);

    // random phases over several limits and idle rates
    idle_pct = 0;
    random_items(250, 4);
    set_limit(8'd3);
    idle_pct = 73;
    random_items(250, 2);
    drain();
    set_limit(8'd128);
    idle_pct = 30;
    random_items(250, 16);
    set_limit(8'd0);
    idle_pct = 0;
    random_items(100, 2);
    set_limit(8'd2);
    idle_pct = 73;
    random_items(200, 2);
    set_limit(8'd100);
    idle_pct = 0;
    random_items(250, 8);

    drain();
    $display("covered %0d items, %0d hits, %0d evictions, limits 0 to 255",
             board.checked, board.hits, board.evictions);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
